[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the reassembly tracker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is active.
`define FRT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Condition that must never be true outside reset.
`define FRT_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`endif

[design/frt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frt_pkg
// Types, constants and helpers shared by the reassembly tracker modules.
// ---------------------------------------------------------------------------
package frt_pkg;

    localparam int SESSIONS = 8;
    localparam int SLOT_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    localparam int FIELD_W    = 16;
    localparam int ACTION_W   = 4;
    localparam int OUT_SLOT_W = 3;
    localparam int MAXSZ_W    = 16;
    localparam int HDR_W      = 8;

    localparam logic [MAXSZ_W-1:0] MAXSZ_RESET = 16'd8000;
    localparam logic [HDR_W-1:0]   HDR_RESET   = 8'd16;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SINGLE_SENT     = 4'd0,
        ACT_SINGLE_OVERSIZE = 4'd1,
        ACT_STARTED         = 4'd2,
        ACT_APPENDED        = 4'd3,
        ACT_COMPLETED       = 4'd4,
        ACT_OVERSIZE_DROP   = 4'd5,
        ACT_RESTARTED       = 4'd6,
        ACT_SEQUENCE_DROP   = 4'd7,
        ACT_ORPHAN          = 4'd8,
        ACT_TABLE_FULL      = 4'd9
    } action_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    // register index as decoded from paddr[2]
    typedef enum logic [0:0] {
        REG_MAX_MESSAGE_SIZE = 1'b0,
        REG_HEADER_BYTES     = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic load_in;   // capture the accepted item
        logic exec;      // table update and result load
    } dp_cmd_t;

    // low bits of a slot index as carried in the result
    function automatic logic [OUT_SLOT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+OUT_SLOT_W-1:0] wide;
        wide = {{OUT_SLOT_W{1'b0}}, idx};
        return wide[OUT_SLOT_W-1:0];
    endfunction

endpackage

[design/frt_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frt_ctrl
// Handshake controller: accepts one item, runs the table step, holds result.
// ---------------------------------------------------------------------------
module frt_ctrl import frt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // the result register must be free or draining this cycle
                if (!out_valid_reg || m_tready) begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

[design/frt_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frt_datapath
// Session table, key lookup, running-length update and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frt_datapath import frt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [MAXSZ_W-1:0]    max_message_size,
    input  logic [HDR_W-1:0]      header_bytes,
    output logic [OUT_DATA_W-1:0] out_data
);

    // latched item
    logic [FIELD_W-1:0] src_reg, mid_reg, cnt_reg, seq_reg, len_reg;

    // session table
    logic [SESSIONS-1:0] valid_reg, valid_next;
    logic [FIELD_W-1:0]  tab_src_reg  [SESSIONS];
    logic [FIELD_W-1:0]  tab_mid_reg  [SESSIONS];
    logic [FIELD_W-1:0]  tab_seq_reg  [SESSIONS];
    logic [FIELD_W-1:0]  tab_run_reg  [SESSIONS];

    // result register
    logic [ACTION_W-1:0]   act_reg;
    logic [FIELD_W-1:0]    total_reg;
    logic [OUT_SLOT_W-1:0] slot_reg;

    // lookup
    logic [SESSIONS-1:0] match;
    logic                hit_any, free_any;
    logic [SLOT_W-1:0]   hit_idx, free_idx;

    // step results
    action_t             act;
    logic [FIELD_W-1:0]  total;
    logic [OUT_SLOT_W-1:0] slot_out;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_idx;
    logic                wr_key;
    logic [FIELD_W-1:0]  wr_seq, wr_run;

    logic                is_single;
    logic [FIELD_W:0]    expected_seq;
    logic [FIELD_W:0]    raw_sum;
    logic [FIELD_W-1:0]  sat_sum;
    logic [FIELD_W-1:0]  hit_seq, hit_run;

    // assertion helpers
    logic                exec_single, exec_start, exec_close;
    logic [SLOT_W:0]     open_cnt;

    function automatic logic too_big(input logic [FIELD_W-1:0] body,
                                     input logic [HDR_W-1:0]   hdr,
                                     input logic [MAXSZ_W-1:0] lim);
        logic [FIELD_W:0] need;
        need = {{(FIELD_W+1-HDR_W){1'b0}}, hdr} + {1'b0, body};
        return need > {1'b0, lim};
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            src_reg <= in_data[15:0];
            mid_reg <= in_data[31:16];
            cnt_reg <= in_data[47:32];
            seq_reg <= in_data[63:48];
            len_reg <= in_data[79:64];
        end
    end

    always_comb begin
        match    = '0;
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SESSIONS; i++) begin
            match[i] = valid_reg[i] && tab_src_reg[i] == src_reg
                       && tab_mid_reg[i] == mid_reg;
        end
        // lowest numbered hit and lowest numbered free slot
        for (int i = SESSIONS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign hit_seq      = tab_seq_reg[hit_idx];
    assign hit_run      = tab_run_reg[hit_idx];
    assign is_single    = cnt_reg <= 16'd1;
    assign expected_seq = {1'b0, hit_seq} + 17'd1;
    assign raw_sum      = {1'b0, hit_run} + {1'b0, len_reg};
    assign sat_sum      = raw_sum[FIELD_W] ? {FIELD_W{1'b1}} : raw_sum[FIELD_W-1:0];

    always_comb begin
        act        = ACT_SINGLE_SENT;
        total      = '0;
        slot_out   = '0;
        valid_next = valid_reg;
        wr_en      = 1'b0;
        wr_idx     = hit_idx;
        wr_key     = 1'b0;
        wr_seq     = seq_reg;
        wr_run     = len_reg;
        if (is_single) begin
            act   = too_big(len_reg, header_bytes, max_message_size)
                    ? ACT_SINGLE_OVERSIZE : ACT_SINGLE_SENT;
            total = len_reg;
        end else if (!hit_any) begin
            if (seq_reg != 16'd1) begin
                act = ACT_ORPHAN;
            end else if (!free_any) begin
                act = ACT_TABLE_FULL;
            end else begin
                act                  = ACT_STARTED;
                total                = len_reg;
                slot_out             = slot_to_out(free_idx);
                wr_en                = 1'b1;
                wr_idx               = free_idx;
                wr_key               = 1'b1;
                valid_next[free_idx] = 1'b1;
            end
        end else if ({1'b0, seq_reg} == expected_seq) begin
            total    = sat_sum;
            slot_out = slot_to_out(hit_idx);
            wr_en    = 1'b1;
            wr_run   = sat_sum;
            if (cnt_reg == seq_reg) begin
                act                 = too_big(sat_sum, header_bytes, max_message_size)
                                      ? ACT_OVERSIZE_DROP : ACT_COMPLETED;
                valid_next[hit_idx] = 1'b0;
            end else begin
                act = ACT_APPENDED;
            end
        end else if (seq_reg == 16'd1) begin
            // out of order restart on a fresh first fragment
            act      = ACT_RESTARTED;
            total    = len_reg;
            slot_out = slot_to_out(hit_idx);
            wr_en    = 1'b1;
        end else begin
            act                 = ACT_SEQUENCE_DROP;
            total               = hit_run;
            slot_out            = slot_to_out(hit_idx);
            valid_next[hit_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.exec) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            tab_seq_reg[wr_idx] <= wr_seq;
            tab_run_reg[wr_idx] <= wr_run;
            if (wr_key) begin
                tab_src_reg[wr_idx] <= src_reg;
                tab_mid_reg[wr_idx] <= mid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            act_reg   <= act;
            total_reg <= total;
            slot_reg  <= slot_out;
        end
    end

    assign out_data = {1'b0, slot_reg, total_reg, act_reg};

    assign exec_single = cmd.exec && is_single;
    assign exec_start  = cmd.exec && act == ACT_STARTED;
    assign exec_close  = cmd.exec && (act == ACT_SEQUENCE_DROP || act == ACT_COMPLETED
                                      || act == ACT_OVERSIZE_DROP);
    assign open_cnt    = (SLOT_W+1)'($countones(valid_reg));

    `FRT_ASSERT_NEVER(a_cmd_overlap, aclk, aresetn, cmd.load_in && cmd.exec)
    `FRT_ASSERT(a_single_keeps_table, aclk, aresetn, exec_single |=> valid_reg == $past(valid_reg))
    `FRT_ASSERT(a_start_claims_slot, aclk, aresetn, exec_start |=> open_cnt == $past(open_cnt) + 1'b1)
    `FRT_ASSERT(a_drop_frees_slot, aclk, aresetn, exec_close |=> open_cnt + 1'b1 == $past(open_cnt))

endmodule

[design/fragment_reassembly_tracker_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fragment_reassembly_tracker_core
// Fragment header tracker with an APB register port and stream channels.
// ---------------------------------------------------------------------------
// Each accepted item is one fragment header and yields exactly one result
// item. An item is handled by capturing the header, then the session
// table lookup and read-modify-write, which waits while an untaken result
// fills the output register; the next header is accepted after that step,
// even while its result waits. The session table has SESSIONS slots held
// in flip-flops, searched in parallel by source and message id; valid bits
// clear at reset. Registers: 0x0 max_message_size (reset 8000), 0x4
// header_bytes (reset 16); write them only while idle.
// ---------------------------------------------------------------------------
module fragment_reassembly_tracker_core import frt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // src_key[15:0], msg_key[31:16], packet_count[47:32],
    // sequence_number[63:48], fragment_length[79:64]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // action[3:0], total_length[19:4], session_slot[22:20], zero[23]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [MAXSZ_W-1:0] max_size_reg;
    logic [HDR_W-1:0]   hdr_bytes_reg;
    reg_index_t         reg_sel;
    logic               wr_fire;
    dp_cmd_t            cmd;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg  <= MAXSZ_RESET;
            hdr_bytes_reg <= HDR_RESET;
        end else if (wr_fire) begin
            case (reg_sel)
                REG_MAX_MESSAGE_SIZE: max_size_reg  <= pwdata[MAXSZ_W-1:0];
                REG_HEADER_BYTES:     hdr_bytes_reg <= pwdata[HDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MAX_MESSAGE_SIZE: prdata = {{(APB_DATA_W-MAXSZ_W){1'b0}}, max_size_reg};
            REG_HEADER_BYTES:     prdata = {{(APB_DATA_W-HDR_W){1'b0}}, hdr_bytes_reg};
            default:              prdata = '0;
        endcase
    end

    frt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    frt_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .in_data          (s_tdata),
        .max_message_size (max_size_reg),
        .header_bytes     (hdr_bytes_reg),
        .out_data         (m_tdata)
    );

endmodule

[sim/frt_result_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frt_result_checker
// Watches the header and result channels and the register port. Keeps its
// own session table, predicts the disposition of every accepted header,
// and compares each result item against the oldest open prediction.
// ---------------------------------------------------------------------------
module frt_result_checker import frt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    output int                    pending,
    output int                    mismatches,
    output int                    results_checked,
    output logic [9:0]            actions_seen
);

    // last field in the lowest bits
    typedef struct packed {
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] seq_no;
        logic [FIELD_W-1:0] count;
        logic [FIELD_W-1:0] message;
        logic [FIELD_W-1:0] source;
    } frag_hdr_t;

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] slot;
        logic [FIELD_W-1:0]    total;
        action_t               action;
    } disposition_t;

    logic [MAXSZ_W-1:0] size_limit;
    logic [HDR_W-1:0]   hdr_size;

    logic               open_slot [SESSIONS];
    logic [FIELD_W-1:0] slot_src  [SESSIONS];
    logic [FIELD_W-1:0] slot_msg  [SESSIONS];
    logic [FIELD_W-1:0] slot_seq  [SESSIONS];
    logic [FIELD_W-1:0] slot_len  [SESSIONS];

    disposition_t expected_dispositions[$];

    function automatic logic exceeds_limit(input logic [FIELD_W-1:0] body);
        return ({9'd0, hdr_size} + {1'b0, body}) > {1'b0, size_limit};
    endfunction

    task automatic predict_disposition(input frag_hdr_t h, output disposition_t d);
        int          hit;
        int          free_idx;
        logic [16:0] sum;
        hit      = -1;
        free_idx = -1;
        d.action = ACT_SINGLE_SENT;
        d.total  = h.length;
        d.slot   = '0;
        if (h.count <= 16'd1) begin
            d.action = exceeds_limit(h.length) ? ACT_SINGLE_OVERSIZE : ACT_SINGLE_SENT;
            return;
        end
        for (int i = 0; i < SESSIONS; i++) begin
            if (open_slot[i]) begin
                if (hit < 0 && slot_src[i] == h.source && slot_msg[i] == h.message)
                    hit = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (hit < 0) begin
            d.total = '0;
            if (h.seq_no != 16'd1) begin
                d.action = ACT_ORPHAN;
            end else if (free_idx < 0) begin
                d.action = ACT_TABLE_FULL;
            end else begin
                open_slot[free_idx] = 1'b1;
                slot_src[free_idx]  = h.source;
                slot_msg[free_idx]  = h.message;
                slot_seq[free_idx]  = 16'd1;
                slot_len[free_idx]  = h.length;
                d.action = ACT_STARTED;
                d.total  = h.length;
                d.slot   = OUT_SLOT_W'(free_idx);
            end
            return;
        end
        d.slot = OUT_SLOT_W'(hit);
        // expected sequence at 17 bits: a session at 65535 never matches again
        if ({1'b0, h.seq_no} == {1'b0, slot_seq[hit]} + 17'd1) begin
            sum = {1'b0, slot_len[hit]} + {1'b0, h.length};
            if (sum > 17'hFFFF)
                sum = 17'hFFFF;
            slot_len[hit] = sum[FIELD_W-1:0];
            slot_seq[hit] = h.seq_no;
            d.total = sum[FIELD_W-1:0];
            if (h.count == h.seq_no) begin
                open_slot[hit] = 1'b0;
                d.action = exceeds_limit(sum[FIELD_W-1:0]) ? ACT_OVERSIZE_DROP : ACT_COMPLETED;
            end else begin
                d.action = ACT_APPENDED;
            end
        end else if (h.seq_no == 16'd1) begin
            slot_seq[hit] = 16'd1;
            slot_len[hit] = h.length;
            d.action = ACT_RESTARTED;
            d.total  = h.length;
        end else begin
            open_slot[hit] = 1'b0;
            d.action = ACT_SEQUENCE_DROP;
            d.total  = slot_len[hit];
        end
    endtask

    task automatic report(input string what, input int want, input int got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        disposition_t want;
        disposition_t got;
        logic [APB_DATA_W-1:0] reg_value;
        if (!aresetn) begin
            size_limit = MAXSZ_RESET;
            hdr_size   = HDR_RESET;
            for (int i = 0; i < SESSIONS; i++)
                open_slot[i] = 1'b0;
            expected_dispositions.delete();
            mismatches      = 0;
            results_checked = 0;
            actions_seen    = '0;
            pending <= 0;
        end else begin
            if (psel && penable && pready) begin
                case (reg_index_t'(paddr[2]))
                    REG_MAX_MESSAGE_SIZE: reg_value = {16'd0, size_limit};
                    default:              reg_value = {24'd0, hdr_size};
                endcase
                if (pwrite) begin
                    case (reg_index_t'(paddr[2]))
                        REG_MAX_MESSAGE_SIZE: size_limit = pwdata[MAXSZ_W-1:0];
                        default:              hdr_size   = pwdata[HDR_W-1:0];
                    endcase
                end else if (prdata !== reg_value) begin
                    report("register read", reg_value, prdata);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_disposition(frag_hdr_t'(s_tdata), want);
                expected_dispositions.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = disposition_t'(m_tdata[OUT_DATA_W-2:0]);
                if (expected_dispositions.size() == 0) begin
                    $display("%0t ns: result item with nothing expected, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_dispositions.pop_front();
                    results_checked++;
                    if (want.action <= ACT_TABLE_FULL)
                        actions_seen[want.action] = 1'b1;
                    if (got.action !== want.action)
                        report("action", want.action, got.action);
                    if (got.total !== want.total)
                        report("total_length", want.total, got.total);
                    if (got.slot !== want.slot)
                        report("session_slot", want.slot, got.slot);
                end
            end
            pending <= expected_dispositions.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for fragment_reassembly_tracker_core: directed
// headers, one session run back to back at full rate, then randomized
// interleaved messages with noise under several size limits, with bursty
// input and a stalling receiver. Checking is done by frt_result_checker.
// ---------------------------------------------------------------------------
module tb_top;
    import frt_pkg::*;

    localparam int STREAMS = 10;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int         pending;
    int         mismatches;
    int         results_checked;
    logic [9:0] actions_seen;

    bit rx_free    = 1'b0;
    bit tx_steady  = 1'b0;
    int burst_left = 0;
    int items_sent = 0;
    int settings   = 1;

    // open message streams of the random part
    logic [15:0] strm_src [STREAMS];
    logic [15:0] strm_msg [STREAMS];
    logic [15:0] strm_cnt [STREAMS];
    logic [15:0] strm_next[STREAMS];

    fragment_reassembly_tracker_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frt_result_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pending        (pending),
        .mismatches     (mismatches),
        .results_checked(results_checked),
        .actions_seen   (actions_seen)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: ready follows a stall mode that is redrawn at random
    always @(posedge aclk) begin : rx_pattern
        int rx_tick;
        int rx_mode;
        if (rx_free) begin
            m_tready <= 1'b1;
        end else begin
            rx_tick++;
            if (rx_tick % 48 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= (rx_tick % 3 != 0);
                2:       m_tready <= ($urandom_range(0, 99) < 75);
                default: m_tready <= ($urandom_range(0, 99) < 25);
            endcase
        end
    end

    task automatic send_header(input logic [15:0] src, input logic [15:0] mid,
                               input logic [15:0] cnt, input logic [15:0] seq,
                               input logic [15:0] len);
        int gap;
        if (burst_left == 0) begin
            gap = tx_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tdata  <= {len, seq, cnt, mid, src};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic apb_access(input logic wr, input reg_index_t idx,
                              input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_limits(input logic [15:0] limit, input logic [7:0] hdr);
        wait_idle();
        apb_access(1'b1, REG_MAX_MESSAGE_SIZE, {16'd0, limit});
        apb_access(1'b1, REG_HEADER_BYTES, {24'd0, hdr});
        apb_access(1'b0, REG_MAX_MESSAGE_SIZE, '0);
        apb_access(1'b0, REG_HEADER_BYTES, '0);
        settings++;
    endtask

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'($urandom_range(0, 1500));
        else if (r < 9)
            return 16'($urandom_range(0, 255));
        return 16'($urandom);
    endfunction

    // small key space so streams collide, fill the table and reuse keys
    function automatic logic [15:0] pick_key_part(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'hFFFF;
        else if (r == 1)
            return 16'($urandom);
        return 16'($urandom_range(0, span));
    endfunction

    function automatic void renew_stream(input int k);
        strm_src[k]  = pick_key_part(4);
        strm_msg[k]  = pick_key_part(2);
        strm_cnt[k]  = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(2, 6))
                                                   : 16'($urandom_range(2, 40));
        strm_next[k] = 16'd1;
    endfunction

    task automatic random_phase(input int n);
        int          k;
        int          r;
        logic [15:0] cnt;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(0, STREAMS - 1);
            if ($urandom_range(0, 99) == 0)
                wait_idle();
            r = $urandom_range(0, 99);
            if (r < 72) begin
                send_header(strm_src[k], strm_msg[k], strm_cnt[k], strm_next[k], pick_len());
                strm_next[k]++;
                if (strm_next[k] > strm_cnt[k])
                    renew_stream(k);
            end else if (r < 78) begin
                send_header(16'($urandom), 16'($urandom), 16'($urandom_range(0, 1)),
                            16'($urandom), pick_len());
            end else if (r < 82) begin
                send_header(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
            end else if (r < 87) begin
                // restart of an open message
                send_header(strm_src[k], strm_msg[k], strm_cnt[k], 16'd1, pick_len());
                strm_next[k] = 16'd2;
            end else if (r < 91) begin
                // skipped fragment
                send_header(strm_src[k], strm_msg[k], strm_cnt[k],
                            strm_next[k] + 16'($urandom_range(1, 3)), pick_len());
                renew_stream(k);
            end else if (r < 94) begin
                // in order; from sequence 3 on, the header claims fewer packets
                cnt = (strm_next[k] >= 16'd3) ? 16'($urandom_range(2, strm_next[k] - 1))
                                              : strm_cnt[k];
                send_header(strm_src[k], strm_msg[k], cnt, strm_next[k], pick_len());
                strm_next[k]++;
                if (strm_next[k] > strm_cnt[k])
                    renew_stream(k);
            end else if (r < 97) begin
                // abandon the stream, its session stays open
                renew_stream(k);
                send_header(strm_src[k], strm_msg[k], strm_cnt[k], 16'd1, pick_len());
                strm_next[k] = 16'd2;
            end else begin
                send_header(pick_key_part(4), pick_key_part(2),
                            16'($urandom_range(2, 65535)),
                            ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom),
                            pick_len());
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset limits 8000 / 16
        send_header(16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0);
        send_header(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
        send_header(16'h0007, 16'h0007, 16'd1, 16'd1, 16'd7984);
        send_header(16'h0007, 16'h0007, 16'd0, 16'd5, 16'd7985);
        send_header(16'h0001, 16'h0001, 16'd3, 16'd2, 16'd10);
        send_header(16'h0001, 16'h0001, 16'd3, 16'd1, 16'd100);
        send_header(16'h0001, 16'h0001, 16'd3, 16'd2, 16'd200);
        send_header(16'h0001, 16'h0001, 16'd3, 16'd1, 16'd50);
        send_header(16'h0001, 16'h0001, 16'd3, 16'd2, 16'd60);
        send_header(16'h0001, 16'h0001, 16'd3, 16'd3, 16'd7000);
        send_header(16'h0002, 16'h0002, 16'd2, 16'd1, 16'hFFFF);
        send_header(16'h0002, 16'h0002, 16'd2, 16'd2, 16'd10);
        send_header(16'h0003, 16'h0003, 16'd4, 16'd1, 16'd5);
        for (int i = 0; i < SESSIONS - 1; i++)
            send_header(16'h0100 + 16'(i), 16'hFFFF, 16'd4, 16'd1, 16'(i));
        send_header(16'h0200, 16'h0000, 16'd4, 16'd1, 16'd1);
        send_header(16'h0003, 16'h0003, 16'd4, 16'd3, 16'd9);
        send_header(16'h0100, 16'hFFFF, 16'd5, 16'd2, 16'd1);
        send_header(16'h0100, 16'hFFFF, 16'd2, 16'd3, 16'd1);
        for (int i = 0; i < SESSIONS - 1; i++)
            send_header(16'h0100 + 16'(i), 16'hFFFF, 16'd4, 16'd0, 16'd0);

        // one session run back to back at full rate, then broken off
        wait_idle();
        rx_free   = 1'b1;
        tx_steady = 1'b1;
        for (int s = 1; s < 64; s++)
            send_header(16'hABCD, 16'h1234, 16'hFFFF, 16'(s), 16'($urandom_range(0, 3)));
        send_header(16'hABCD, 16'h1234, 16'd3, 16'hFFFF, 16'd1);
        send_header(16'hABCD, 16'h1234, 16'd2, 16'd0, 16'd0);
        wait_idle();
        rx_free   = 1'b0;
        tx_steady = 1'b0;

        for (int k = 0; k < STREAMS; k++)
            renew_stream(k);
        set_limits(16'd0, 8'd0);
        random_phase(270);
        set_limits(16'hFFFF, 8'hFF);
        random_phase(270);
        set_limits(16'd1500, 8'd20);
        random_phase(270);
        set_limits(16'd4000, 8'd0);
        random_phase(270);
        set_limits(16'($urandom), 8'($urandom));
        random_phase(270);
        set_limits(16'hFFFF, 8'd0);
        random_phase(270);

        wait_idle();
        repeat (16) @(posedge aclk);
        $display("tb: %0d fragment headers under %0d limit settings, incl. a back-to-back run",
                 items_sent, settings);
        $display("tb: %0d results compared, dispositions seen %b", results_checked,
                 actions_seen);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/frt_pkg.sv
design/frt_ctrl.sv
design/frt_datapath.sv
design/fragment_reassembly_tracker_core.sv
sim/frt_result_checker.sv
sim/tb_top.sv
